// ----- rtl/srtf_preemptive_scheduler_core_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the scheduler
// Concurrent assertion helpers that vanish in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef SRTF_PREEMPTIVE_SCHEDULER_CORE_MACROS_SVH
`define SRTF_PREEMPTIVE_SCHEDULER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SRTF_ASSERT(lbl, clk_i, rst_ni, prop) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error("%m failed");
`define SRTF_ASSERT_NEXT(lbl, clk_i, rst_ni, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
		else $error("%m failed");
`else
`define SRTF_ASSERT(lbl, clk_i, rst_ni, prop)
`define SRTF_ASSERT_NEXT(lbl, clk_i, rst_ni, ante, cons)
`endif
`endif

// ----- rtl/srtf_pkg.sv -----
// ----------------------------------------------------------------------------
// Scheduler package
// Shared constants and types of the scheduler.
// ----------------------------------------------------------------------------
package srtf_pkg;
	localparam int MaxJobs = 16;
	localparam int BurstBits = 16;
	localparam int TimeBits = 32;
	localparam int IdBits = 4;
	localparam int InBurstBits = 16;

	typedef struct packed {
		logic             arrival_valid;
		logic [IdBits-1:0] arrival_id;
		logic [InBurstBits-1:0] arrival_burst;
	} tick_t;
endpackage

// ----- rtl/srtf_fifo.sv -----
// ----------------------------------------------------------------------------
// Tick queue
// Two-entry queue between the intake and the scheduling engine.
// ----------------------------------------------------------------------------
module srtf_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_valid,
	output logic            wr_ready,
	input  srtf_pkg::tick_t wr_data,
	output logic            rd_valid,
	input  logic            rd_ready,
	output srtf_pkg::tick_t rd_data
);
	srtf_pkg::tick_t mem_q [2];
	logic            wp_q, rp_q;
	logic [1:0]      cnt_q;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_data  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_valid && wr_ready) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_valid && wr_ready) wp_q <= ~wp_q;
			if (rd_valid && rd_ready) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
		end
	end
endmodule

// ----- rtl/srtf_engine.sv -----
// ----------------------------------------------------------------------------
// Scheduling engine
// Admits a job, picks the job to run (a table scan when none runs, else a preemption check), serves one unit.
// ----------------------------------------------------------------------------
`include "srtf_preemptive_scheduler_core_macros.svh"
module srtf_engine #(
	parameter int MAX_JOBS   = srtf_pkg::MaxJobs,
	parameter int BURST_BITS = srtf_pkg::BurstBits,
	parameter int TIME_BITS  = srtf_pkg::TimeBits
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            tick_valid,
	output logic            tick_ready,
	input  srtf_pkg::tick_t tick,
	output logic            out_valid,
	input  logic            out_ready,
	output logic            busy_res,
	output logic [3:0]      running_id,
	output logic            done_res,
	output logic [3:0]      done_id,
	output logic [31:0]     turnaround,
	output logic [31:0]     wait_time,
	output logic [31:0]     turnaround_sum,
	output logic [31:0]     total_wait,
	output logic            dropped
);
	localparam int SB = $clog2(MAX_JOBS);
	localparam int CB = $clog2(MAX_JOBS + 1);
	localparam logic [31:0] W32 = 32'hFFFF_FFFF;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_ADMIT = 4'b0010,
		ST_SCAN  = 4'b0100,
		ST_SERVE = 4'b1000
	} state_t;

	state_t                state_q;
	logic [MAX_JOBS-1:0]   valid_q;
	logic [3:0]            jid_q   [MAX_JOBS];
	logic [BURST_BITS-1:0] rem_q   [MAX_JOBS];
	logic [BURST_BITS-1:0] burst_q [MAX_JOBS];
	logic [TIME_BITS-1:0]  arr_q   [MAX_JOBS];
	logic [SB-1:0]         cur_q, best_q, new_q;
	logic                  cur_v_q, found_q, new_ok_q;
	logic                  drop_q;
	logic [CB-1:0]         idx_q;
	logic [TIME_BITS-1:0]  time_q;
	logic [31:0]           sum_ta_q, sum_wt_q;
	srtf_pkg::tick_t       tick_q;

	logic [BURST_BITS-1:0] abur;
	logic                  free_f;
	logic [SB-1:0]         free_s;
	logic [SB-1:0]         scan_s;
	logic                  better;
	logic [BURST_BITS-1:0] rem_m1;
	logic [TIME_BITS-1:0]  t_full;
	logic [31:0]           ta_c, wt_c;
	logic [32:0]           s_ta, s_wt;
	logic                  serve_go;

	always_comb begin
		if (BURST_BITS >= srtf_pkg::InBurstBits)
			abur = BURST_BITS'(tick_q.arrival_burst);
		else if (|(tick_q.arrival_burst >> BURST_BITS))
			abur = '1;
		else
			abur = BURST_BITS'(tick_q.arrival_burst);
	end

	always_comb begin
		free_f = 1'b0;
		free_s = '0;
		for (int i = MAX_JOBS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_f = 1'b1;
				free_s = SB'(i);
			end
		end
	end

	assign scan_s = idx_q[SB-1:0];
	always_comb begin
		if (rem_q[scan_s] != rem_q[best_q]) better = rem_q[scan_s] < rem_q[best_q];
		else better = arr_q[scan_s] < arr_q[best_q];
	end

	assign rem_m1 = rem_q[cur_q] - 1'b1;
	assign t_full = time_q + 1'b1 - arr_q[cur_q];
	always_comb begin
		if (TIME_BITS > 32 && |(t_full >> 32)) ta_c = W32;
		else ta_c = 32'(t_full);
		wt_c = (ta_c >= 32'(burst_q[cur_q])) ? ta_c - 32'(burst_q[cur_q]) : 32'd0;
	end
	assign s_ta = {1'b0, sum_ta_q} + {1'b0, ta_c};
	assign s_wt = {1'b0, sum_wt_q} + {1'b0, wt_c};

	assign serve_go = state_q == ST_SERVE && (!out_valid || out_ready);

	assign tick_ready = state_q == ST_IDLE;

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && tick_valid) tick_q <= tick;
		if (state_q == ST_ADMIT && tick_q.arrival_valid && abur != '0 && free_f) begin
			jid_q[free_s]   <= tick_q.arrival_id;
			rem_q[free_s]   <= abur;
			burst_q[free_s] <= abur;
			arr_q[free_s]   <= time_q;
		end
		if (serve_go && cur_v_q) rem_q[cur_q] <= rem_m1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
			cur_q <= '0;
			cur_v_q <= 1'b0;
			best_q <= '0;
			found_q <= 1'b0;
			new_q <= '0;
			new_ok_q <= 1'b0;
			drop_q <= 1'b0;
			idx_q <= '0;
			time_q <= '0;
			sum_ta_q <= '0;
			sum_wt_q <= '0;
			out_valid <= 1'b0;
			busy_res <= 1'b0;
			running_id <= '0;
			done_res <= 1'b0;
			done_id <= '0;
			turnaround <= '0;
			wait_time <= '0;
			turnaround_sum <= '0;
			total_wait <= '0;
			dropped <= 1'b0;
		end else begin
			if (out_valid && out_ready && state_q != ST_SERVE) out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (tick_valid) state_q <= ST_ADMIT;
				end
				ST_ADMIT: begin
					drop_q <= 1'b0;
					new_ok_q <= 1'b0;
					if (cur_v_q && !valid_q[cur_q]) cur_v_q <= 1'b0;
					if (tick_q.arrival_valid) begin
						if (abur == '0 || !free_f) drop_q <= 1'b1;
						else begin
							valid_q[free_s] <= 1'b1;
							new_q <= free_s;
							new_ok_q <= 1'b1;
						end
					end
					idx_q <= '0;
					found_q <= 1'b0;
					best_q <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (cur_v_q) begin
						if (new_ok_q && rem_q[new_q] < rem_q[cur_q]) cur_q <= new_q;
						state_q <= ST_SERVE;
					end else if (idx_q == CB'(MAX_JOBS)) begin
						if (found_q) begin
							cur_q <= best_q;
							cur_v_q <= 1'b1;
						end
						state_q <= ST_SERVE;
					end else begin
						if (valid_q[scan_s] && (!found_q || better)) begin
							best_q <= scan_s;
							found_q <= 1'b1;
						end
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_SERVE: begin
					if (!out_valid || out_ready) begin
						busy_res <= cur_v_q;
						running_id <= cur_v_q ? jid_q[cur_q] : 4'd0;
						done_res <= 1'b0;
						done_id <= '0;
						turnaround <= '0;
						wait_time <= '0;
						turnaround_sum <= sum_ta_q;
						total_wait <= sum_wt_q;
						dropped <= drop_q;
						if (cur_v_q && rem_m1 == '0) begin
							done_res <= 1'b1;
							done_id <= jid_q[cur_q];
							turnaround <= ta_c;
							wait_time <= wt_c;
							sum_ta_q <= s_ta[32] ? W32 : s_ta[31:0];
							sum_wt_q <= s_wt[32] ? W32 : s_wt[31:0];
							turnaround_sum <= s_ta[32] ? W32 : s_ta[31:0];
							total_wait <= s_wt[32] ? W32 : s_wt[31:0];
							valid_q[cur_q] <= 1'b0;
							cur_v_q <= 1'b0;
						end
						time_q <= time_q + 1'b1;
						out_valid <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`SRTF_ASSERT(a_done_busy, clk, arst_n, out_valid |-> (!done_res || busy_res))
	`SRTF_ASSERT(a_cur_live, clk, arst_n, (state_q == ST_IDLE && cur_v_q) |-> valid_q[cur_q])
	`SRTF_ASSERT_NEXT(a_serve_out, clk, arst_n, state_q == ST_SERVE, out_valid)
endmodule

// ----- rtl/srtf_preemptive_scheduler_core.sv -----
// ----------------------------------------------------------------------------
// SRTF preemptive scheduler core
// Top level: intake queue and scheduling engine.
// ----------------------------------------------------------------------------
// Each input beat is one time tick carrying an optional job arrival
// (arrival_valid, arrival_id, arrival_burst). Each accepted tick yields
// exactly one output beat: the job served in that tick, a completion report
// with turnaround and waiting time, the saturating totals and a drop flag.
// The intake queue holds two ticks, so the input side keeps accepting while
// the engine works. When a job is already running, the engine passes each
// tick through admit, scan and service with only a preemption check;
// otherwise a linear scan over the job table, one slot per cycle, picks
// the job to run. The result of each tick is registered at its service
// step; queued ticks wait for the ticks ahead of them.
// When the receiver stalls, the result waits in the output register while
// the engine works the next tick up to its service step and holds there;
// further ticks then pile into the queue until it is full.
// Reset empties the table, the queue and clears time and totals.
// ----------------------------------------------------------------------------
module srtf_preemptive_scheduler_core #(
	parameter int MAX_JOBS   = srtf_pkg::MaxJobs,
	parameter int BURST_BITS = srtf_pkg::BurstBits,
	parameter int TIME_BITS  = srtf_pkg::TimeBits
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        arrival_valid,
	input  logic [3:0]  arrival_id,
	input  logic [15:0] arrival_burst,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        busy_res,
	output logic [3:0]  running_id,
	output logic        done_res,
	output logic [3:0]  done_id,
	output logic [31:0] turnaround,
	output logic [31:0] wait_time,
	output logic [31:0] turnaround_sum,
	output logic [31:0] total_wait,
	output logic        dropped
);
	srtf_pkg::tick_t in_tick, q_tick;
	logic            q_valid, q_ready;

	assign in_tick.arrival_valid = arrival_valid;
	assign in_tick.arrival_id    = arrival_id;
	assign in_tick.arrival_burst = arrival_burst;

	srtf_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(in_valid), .wr_ready(in_ready), .wr_data(in_tick),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_tick)
	);

	srtf_engine #(
		.MAX_JOBS(MAX_JOBS), .BURST_BITS(BURST_BITS), .TIME_BITS(TIME_BITS)
	) u_engine (
		.clk(clk), .arst_n(arst_n),
		.tick_valid(q_valid), .tick_ready(q_ready), .tick(q_tick),
		.out_valid(out_valid), .out_ready(out_ready),
		.busy_res(busy_res), .running_id(running_id),
		.done_res(done_res), .done_id(done_id),
		.turnaround(turnaround), .wait_time(wait_time),
		.turnaround_sum(turnaround_sum), .total_wait(total_wait),
		.dropped(dropped)
	);
endmodule

// ----- bench/srtf_preemptive_scheduler_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SRTF scheduler testbench
// Drives directed, then random time ticks with job arrivals and idle gaps on both sides,
// predicts every result beat from a shadow job table and checks each field.
// ----------------------------------------------------------------------------
module srtf_preemptive_scheduler_core_tb;

	typedef struct packed {
		logic        busy;
		logic [3:0]  run_id;
		logic        done;
		logic [3:0]  fin_id;
		logic [31:0] ta;
		logic [31:0] wt;
		logic [31:0] sum_ta;
		logic [31:0] sum_wt;
		logic        drop;
	} tick_result_t;

	class sched_scoreboard;
		logic              used [srtf_pkg::MaxJobs];
		logic [3:0]        job_id [srtf_pkg::MaxJobs];
		logic [15:0]       remaining [srtf_pkg::MaxJobs];
		logic [15:0]       burst [srtf_pkg::MaxJobs];
		logic [31:0]       arrived [srtf_pkg::MaxJobs];
		int unsigned       cur;
		logic              cur_ok;
		logic [31:0]       now;
		logic [31:0]       sum_ta;
		logic [31:0]       sum_wt;
		tick_result_t      expected_q [$];
		int                errors;

		function new();
			for (int i = 0; i < srtf_pkg::MaxJobs; i++) used[i] = 0;
			cur = 0;
			cur_ok = 0;
			now = 0;
			sum_ta = 0;
			sum_wt = 0;
			errors = 0;
		endfunction

		function logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
			logic [32:0] s;
			s = {1'b0, a} + {1'b0, b};
			return s[32] ? 32'hFFFF_FFFF : s[31:0];
		endfunction

		function bit beats(int a, int b);
			if (remaining[a] != remaining[b]) return remaining[a] < remaining[b];
			if (arrived[a] != arrived[b]) return arrived[a] < arrived[b];
			return a < b;
		endfunction

		function void note_tick(logic arr, logic [3:0] id, logic [15:0] bst);
			tick_result_t r;
			int slot;
			int best;
			logic [31:0] t;
			r = '0;
			slot = -1;
			if (cur_ok && !used[cur]) cur_ok = 0;
			if (arr) begin
				if (bst == 0) begin
					r.drop = 1;
				end else begin
					for (int i = 0; i < srtf_pkg::MaxJobs; i++)
						if (!used[i] && slot < 0) slot = i;
					if (slot < 0) begin
						r.drop = 1;
					end else begin
						used[slot] = 1;
						job_id[slot] = id;
						remaining[slot] = bst;
						burst[slot] = bst;
						arrived[slot] = now;
					end
				end
			end
			if (cur_ok) begin
				if (slot >= 0 && remaining[slot] < remaining[cur]) cur = slot;
			end else begin
				best = -1;
				for (int i = 0; i < srtf_pkg::MaxJobs; i++)
					if (used[i] && (best < 0 || beats(i, best))) best = i;
				if (best >= 0) begin
					cur = best;
					cur_ok = 1;
				end
			end
			if (cur_ok) begin
				r.busy = 1;
				r.run_id = job_id[cur];
				remaining[cur] = remaining[cur] - 1;
				if (remaining[cur] == 0) begin
					t = now + 1 - arrived[cur];
					r.ta = t;
					r.wt = (t >= burst[cur]) ? t - burst[cur] : 0;
					r.done = 1;
					r.fin_id = job_id[cur];
					sum_ta = sat_add(sum_ta, r.ta);
					sum_wt = sat_add(sum_wt, r.wt);
					used[cur] = 0;
					cur_ok = 0;
				end
			end
			now = now + 1;
			r.sum_ta = sum_ta;
			r.sum_wt = sum_wt;
			expected_q.insert(expected_q.size(), r);
		endfunction

		function void check_result(tick_result_t act);
			tick_result_t exp_r;
			if (expected_q.size() == 0) begin
				$display("%0t: result beat with nothing expected, got %h", $time, act);
				errors++;
				return;
			end
			exp_r = expected_q[0];
			expected_q.delete(0);
			if (exp_r.busy !== act.busy || exp_r.run_id !== act.run_id
					|| exp_r.done !== act.done || exp_r.fin_id !== act.fin_id
					|| exp_r.ta !== act.ta || exp_r.wt !== act.wt
					|| exp_r.sum_ta !== act.sum_ta || exp_r.sum_wt !== act.sum_wt
					|| exp_r.drop !== act.drop) begin
				$display("%0t: mismatch busy/run/done/fin/ta/wt/sta/swt/drop", $time);
				$display("  expected %0d %0d %0d %0d %0d %0d %0d %0d %0d", exp_r.busy,
					exp_r.run_id, exp_r.done, exp_r.fin_id, exp_r.ta, exp_r.wt,
					exp_r.sum_ta, exp_r.sum_wt, exp_r.drop);
				$display("  actual   %0d %0d %0d %0d %0d %0d %0d %0d %0d", act.busy,
					act.run_id, act.done, act.fin_id, act.ta, act.wt,
					act.sum_ta, act.sum_wt, act.drop);
				errors++;
			end
		endfunction
	endclass

	localparam int StallLimit = 5000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        arrival_valid;
	logic [3:0]  arrival_id;
	logic [15:0] arrival_burst;
	logic        out_valid;
	logic        out_ready;
	logic        busy_res;
	logic [3:0]  running_id;
	logic        done_res;
	logic [3:0]  done_id;
	logic [31:0] turnaround;
	logic [31:0] wait_time;
	logic [31:0] turnaround_sum;
	logic [31:0] total_wait;
	logic        dropped;

	sched_scoreboard sb;
	int              quiet_cycles;
	bit              no_idle;

	srtf_preemptive_scheduler_core u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.arrival_valid(arrival_valid), .arrival_id(arrival_id),
		.arrival_burst(arrival_burst),
		.out_valid(out_valid), .out_ready(out_ready),
		.busy_res(busy_res), .running_id(running_id), .done_res(done_res),
		.done_id(done_id), .turnaround(turnaround), .wait_time(wait_time),
		.turnaround_sum(turnaround_sum), .total_wait(total_wait),
		.dropped(dropped)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	task automatic send_tick(logic arr, logic [3:0] id, logic [15:0] bst);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		arrival_valid <= arr;
		arrival_id <= id;
		arrival_burst <= bst;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_tick(arr, id, bst);
	endtask

	task automatic send_random_tick();
		int kind;
		logic [15:0] bst;
		kind = $urandom_range(0, 99);
		if (kind < 3) bst = 16'($urandom_range(0, 65535));
		else if (kind < 8) bst = 16'd0;
		else bst = 16'($urandom_range(1, 8));
		send_tick(kind < 80, 4'($urandom_range(0, 15)), bst);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result('{busy_res, running_id, done_res, done_id, turnaround,
				wait_time, turnaround_sum, total_wait, dropped});
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > StallLimit) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int gap;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			gap = no_idle ? 0 : $urandom_range(0, 5);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	initial begin
		sb = new();
		quiet_cycles = 0;
		no_idle = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		arrival_valid = 1'b0;
		arrival_id = 4'd0;
		arrival_burst = 16'd0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_tick(1'b0, 4'd0, 16'd0);
		send_tick(1'b1, 4'd15, 16'd0);
		send_tick(1'b1, 4'd0, 16'd1);
		send_tick(1'b1, 4'd5, 16'd65535);
		send_tick(1'b1, 4'd6, 16'd3);
		send_tick(1'b1, 4'd6, 16'd3);
		send_tick(1'b1, 4'd7, 16'd2);
		for (int i = 0; i < 15; i++)
			send_tick(1'b1, i[3:0], 16'd20 + i[15:0]);
		send_tick(1'b0, 4'd0, 16'd0);

		for (int n = 0; n < 650; n++) begin
			no_idle = (n % 200) >= 170;
			send_random_tick();
		end
		no_idle = 0;
		in_valid <= 1'b0;

		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (sb.errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
